FILE: hw/rtl/thrc_pkg.sv
// Shared types and constants of the thermostat run/rest controller.
`default_nettype none

package thrc_pkg;

    localparam int unsigned MS_PER_MINUTE = 60000;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HVAC_MODE        = 3'd0,
        CFG_HEAT_SETPOINT    = 3'd1,
        CFG_COOL_SETPOINT    = 3'd2,
        CFG_SWING            = 3'd3,
        CFG_MIN_RUN_MINUTES  = 3'd4,
        CFG_MIN_REST_MINUTES = 3'd5,
        CFG_HEAT_ACTIVE_HIGH = 3'd6,
        CFG_COOL_ACTIVE_HIGH = 3'd7
    } cfg_index_t;

    localparam logic [1:0] MODE_OFF       = 2'd0;
    localparam logic [1:0] MODE_HEAT      = 2'd1;
    localparam logic [1:0] MODE_COOL      = 2'd2;
    localparam logic [1:0] MODE_HEAT_COOL = 2'd3;

    localparam logic [1:0] STATE_WAITING = 2'd0;
    localparam logic [1:0] STATE_HEATING = 2'd1;
    localparam logic [1:0] STATE_COOLING = 2'd2;
    localparam logic [1:0] STATE_PENDING = 2'd3;

    typedef struct packed {
        logic        [1:0]  hvac_mode;
        logic signed [11:0] heat_setpoint;
        logic signed [11:0] cool_setpoint;
        logic        [7:0]  swing;
        logic        [7:0]  min_run_minutes;
        logic        [7:0]  min_rest_minutes;
        logic               heat_active_high;
        logic               cool_active_high;
    } cfg_t;

    typedef struct packed {
        logic signed [11:0] temperature;
        logic        [31:0] now_ms;
        logic               door_lockout;
    } in_item_t;

    typedef struct packed {
        logic [1:0] hvac_state;
        logic       heat_relay;
        logic       cool_relay;
        logic       motion_ack;
    } out_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/thrc_cfg_regs.sv
// Configuration register file of the thermostat run/rest controller.
`default_nettype none

module thrc_cfg_regs
    import thrc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_HVAC_MODE:        cfg_next.hvac_mode        = cfg_data[1:0];
                CFG_HEAT_SETPOINT:    cfg_next.heat_setpoint    = $signed(cfg_data[11:0]);
                CFG_COOL_SETPOINT:    cfg_next.cool_setpoint    = $signed(cfg_data[11:0]);
                CFG_SWING:            cfg_next.swing            = cfg_data[7:0];
                CFG_MIN_RUN_MINUTES:  cfg_next.min_run_minutes  = cfg_data[7:0];
                CFG_MIN_REST_MINUTES: cfg_next.min_rest_minutes = cfg_data[7:0];
                CFG_HEAT_ACTIVE_HIGH: cfg_next.heat_active_high = cfg_data[0];
                CFG_COOL_ACTIVE_HIGH: cfg_next.cool_active_high = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hvac_mode        <= MODE_OFF;
            cfg_reg.heat_setpoint    <= 12'sd500;
            cfg_reg.cool_setpoint    <= 12'sd850;
            cfg_reg.swing            <= 8'd10;
            cfg_reg.min_run_minutes  <= 8'd5;
            cfg_reg.min_rest_minutes <= 8'd5;
            cfg_reg.heat_active_high <= 1'b1;
            cfg_reg.cool_active_high <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/thrc_ctrl.sv
// Run/rest state machine with hysteresis, run and rest timers.
`default_nettype none

module thrc_ctrl
    import thrc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  wire in_item_t item,
    input  wire cfg_t     cfg,
    output out_item_t     result
);

    typedef enum logic [1:0] {
        WAITING = STATE_WAITING,
        HEATING = STATE_HEATING,
        COOLING = STATE_COOLING,
        PENDING = STATE_PENDING
    } run_state_t;

    run_state_t  state_reg, state_next, state_mid;
    logic [31:0] run_start_reg, run_start_next;
    logic [31:0] run_end_reg, run_end_next, run_end_mid;
    logic        rest_valid_reg, rest_valid_next, rest_valid_mid;
    logic        ack;

    logic signed [13:0] temp_x;
    logic signed [13:0] heat_hi, heat_lo, cool_hi, cool_lo;
    logic signed [13:0] swing_x;
    logic [23:0] run_min_ms, rest_min_ms;
    logic [31:0] run_elapsed, rest_elapsed;
    logic        can_heat, can_cool, locked, running_mid, run_ok, in_rest;
    logic        heat_demand, cool_demand;

    // Thresholds are exact at 14 bits.
    assign temp_x  = $signed({{2{item.temperature[11]}}, item.temperature});
    assign swing_x = $signed({6'b0, cfg.swing});
    assign heat_hi = $signed({{2{cfg.heat_setpoint[11]}}, cfg.heat_setpoint}) + swing_x;
    assign heat_lo = $signed({{2{cfg.heat_setpoint[11]}}, cfg.heat_setpoint}) - swing_x;
    assign cool_hi = $signed({{2{cfg.cool_setpoint[11]}}, cfg.cool_setpoint}) + swing_x;
    assign cool_lo = $signed({{2{cfg.cool_setpoint[11]}}, cfg.cool_setpoint}) - swing_x;

    assign run_min_ms  = 24'(cfg.min_run_minutes)  * 24'(MS_PER_MINUTE);
    assign rest_min_ms = 24'(cfg.min_rest_minutes) * 24'(MS_PER_MINUTE);

    assign can_heat = (cfg.hvac_mode == MODE_HEAT) || (cfg.hvac_mode == MODE_HEAT_COOL);
    assign can_cool = (cfg.hvac_mode == MODE_COOL) || (cfg.hvac_mode == MODE_HEAT_COOL);
    assign locked   = (cfg.hvac_mode == MODE_HEAT_COOL) && item.door_lockout;

    // Drop a run that the mode no longer allows; a dropped cooling run starts a rest.
    always_comb
    begin
        state_mid      = state_reg;
        run_end_mid    = run_end_reg;
        rest_valid_mid = rest_valid_reg;
        if (!can_heat && state_reg == HEATING)
        begin
            state_mid = WAITING;
        end
        if (!can_cool && state_reg == COOLING)
        begin
            state_mid      = WAITING;
            run_end_mid    = item.now_ms;
            rest_valid_mid = 1'b1;
        end
    end

    assign running_mid  = (state_mid == HEATING) || (state_mid == COOLING);
    assign run_elapsed  = item.now_ms - run_start_reg;
    assign rest_elapsed = item.now_ms - run_end_mid;
    assign run_ok       = running_mid && (run_elapsed >= {8'd0, run_min_ms});
    assign in_rest      = !running_mid && rest_valid_mid
                          && (rest_elapsed < {8'd0, rest_min_ms});
    assign heat_demand  = can_heat && (temp_x < heat_lo);
    assign cool_demand  = can_cool && (temp_x > cool_hi);

    always_comb
    begin
        state_next      = state_mid;
        run_start_next  = run_start_reg;
        run_end_next    = run_end_mid;
        rest_valid_next = rest_valid_mid;
        ack             = 1'b0;
        if (cfg.hvac_mode == MODE_OFF)
        begin
            state_next      = state_reg;
            run_end_next    = run_end_reg;
            rest_valid_next = rest_valid_reg;
            if (state_reg != WAITING)
            begin
                state_next      = WAITING;
                run_end_next    = item.now_ms;
                rest_valid_next = 1'b1;
                ack             = 1'b1;
            end
        end
        else
        begin
            ack = (state_mid != state_reg);
            if (state_mid == HEATING)
            begin
                if (locked || (temp_x > heat_hi && run_ok))
                begin
                    state_next      = locked ? PENDING : WAITING;
                    run_end_next    = item.now_ms;
                    rest_valid_next = 1'b1;
                    ack             = 1'b1;
                end
            end
            else if (heat_demand && locked)
            begin
                state_next = PENDING;
                ack        = 1'b1;
            end
            else if (heat_demand && !in_rest)
            begin
                state_next      = HEATING;
                run_start_next  = item.now_ms;
                run_end_next    = 32'd0;
                rest_valid_next = 1'b0;
                ack             = 1'b1;
            end
            else if (state_mid == COOLING)
            begin
                if (locked || (temp_x < cool_lo && run_ok))
                begin
                    state_next      = locked ? PENDING : WAITING;
                    run_end_next    = item.now_ms;
                    rest_valid_next = 1'b1;
                    ack             = 1'b1;
                end
            end
            else if (cool_demand && locked)
            begin
                state_next = PENDING;
                ack        = 1'b1;
            end
            else if (cool_demand && !in_rest)
            begin
                state_next      = COOLING;
                run_start_next  = item.now_ms;
                run_end_next    = 32'd0;
                rest_valid_next = 1'b0;
                ack             = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= WAITING;
            run_start_reg  <= 32'd0;
            run_end_reg    <= 32'd0;
            rest_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            state_reg      <= state_next;
            run_start_reg  <= run_start_next;
            run_end_reg    <= run_end_next;
            rest_valid_reg <= rest_valid_next;
        end
    end

    assign result.hvac_state = 2'(state_next);
    assign result.heat_relay = (state_next == HEATING) ? cfg.heat_active_high
                                                       : ~cfg.heat_active_high;
    assign result.cool_relay = (state_next == COOLING) ? cfg.cool_active_high
                                                       : ~cfg.cool_active_high;
    assign result.motion_ack = ack;

endmodule

`default_nettype wire

FILE: hw/rtl/thermostat_run_rest_controller_core.sv
// Top level of the thermostat run/rest controller: request registers and core.
`default_nettype none

// Thermostat run/rest controller. Every poll request (temperature, millisecond
// time, door lockout) yields exactly one result request carrying the run
// state, both relay levels at their configured polarity and a one-poll
// acknowledge pulse. Heating starts below heat_setpoint - swing and stops
// above heat_setpoint + swing, cooling mirrors that around cool_setpoint;
// a run may be stopped by temperature only after min_run_minutes, and a new
// run waits min_rest_minutes after the end of the last one. Elapsed times
// wrap modulo 2^32 ms. Only heat-cool mode obeys the door lockout.
// Rate: one poll per clock cycle sustained while out_ready stays high; a
// poll passes through the input register, then the result register, and
// waits in the input register while an untaken result holds the result
// register. The controller makes a single compare-and-select pass, which
// reads and updates the run state between those two registers.
// The poll channel keeps accepting while a result waits to be taken, until
// both registers are full. Configuration writes are taken every cycle
// (cfg_ready is always high) and must only be issued while the block is idle.
module thermostat_run_rest_controller_core
    import thrc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_item_t               in_item,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_item_t                   out_item,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t      cfg;
    in_item_t  in_item_reg;
    out_item_t out_item_reg;
    out_item_t result;
    logic      in_full_reg, in_full_next;
    logic      out_valid_reg, out_valid_next;
    logic      advance;
    logic      in_take;

    assign cfg_ready = 1'b1;

    thrc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance the held poll whenever the result slot is free or being emptied.
    assign advance  = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_full_reg || advance;
    assign in_take  = in_valid && in_ready;

    thrc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_take)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: hold until replaced, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef ASSERT_OFF
    // A full input register behind a stalled result must block new polls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("poll accepted while both stages are stalled");

    // A poll that advances must show up as a result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("advanced poll produced no result");

    // Heat relay level agrees with the reported state and polarity.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_item.hvac_state == STATE_HEATING)
                       == (out_item.heat_relay == cfg.heat_active_high)))
        else $error("heat relay disagrees with state");

    // Cool relay level agrees with the reported state and polarity.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_item.hvac_state == STATE_COOLING)
                       == (out_item.cool_relay == cfg.cool_active_high)))
        else $error("cool relay disagrees with state");
`endif

endmodule

`default_nettype wire
